// ===== rtl/scs_pkg.sv =====
package scs_pkg;

   // number of cascades the block is built for
   localparam int MAX_CASCADES = 4;

   // smallest distance, 0.001 in Q16.16
   localparam logic [31:0] MIN_DISTANCE = 32'd66;

   // Q16.16 one and two, and the cap on powers and series values
   localparam logic [32:0] ONE_Q   = 33'h0_0001_0000;
   localparam logic [32:0] TWO_Q   = 33'h0_0002_0000;
   localparam logic [32:0] POW_CAP = 33'h1_0000_0000;

   // divider operand widths
   localparam int DIV_NUM_W = 39;
   localparam int DIV_DEN_W = 32;

   // ceil(2^22 / 5), exact x / 5 as (x * RECIP5) >> 22 for x below 2^22
   localparam logic [19:0] RECIP5 = 20'd838861;

endpackage

// ===== rtl/scs_div.sv =====
module scs_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scs_pkg::DIV_NUM_W-1:0]   num,
   input  logic [scs_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [scs_pkg::DIV_NUM_W-1:0]   quo
);

   localparam int NumW = scs_pkg::DIV_NUM_W;
   localparam int DenW = scs_pkg::DIV_DEN_W;
   localparam int CntW = $clog2(NumW + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CntW-1:0]   cnt_ff;
   logic [DenW-1:0]   rem_ff;
   logic [NumW-1:0]   quo_ff;
   logic [DenW:0]     trial;
   logic              fits;

   // one restoring step: shift in the next numerator bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[NumW-1]};
      fits  = trial >= {1'b0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(NumW);
            rem_ff  <= '0;
            quo_ff  <= num;
         end else if (busy_ff) begin
            rem_ff <= fits ? DenW'(trial - {1'b0, den}) : trial[DenW-1:0];
            quo_ff <= {quo_ff[NumW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/shadow_cascade_split.sv =====
// Cascaded shadow split distances.
// req channel: one transaction carries a requested shadow distance (Q16.16).
// It is clamped to at least 0.001; a value equal to the stored distance gives
// no result, any other value is stored and gives one rsp transaction per
// cascade, in order, with tlast on the final one (which also carries the
// inverse falloff). csr_we/csr_wdata set the cascade count n, taken when idle.
// The block works on one distance at a time: req_tready is low from accept
// until the last result has been loaded into the output register.
// With one cascade only the divider runs, for the inverse falloff. With n
// cascades the scale root takes 32 bisection rounds on the shared 33x16
// multiplier, each raising the midpoint to the power n-1; each cascade but the
// last uses the shared 39-step divider for the blend and the multiplier for the
// next scale, every cascade a multiply by one fifth for the overlap, and the
// last cascade the divider once for the inverse falloff.
// Results wait in a single output register; a stalled receiver holds the
// sequencer in its emit step. Reset clears the stored distance to zero, sets
// the cascade count to one and drops any result in flight.
module shadow_cascade_split (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] requested_distance
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // [2:0] cascade_index, [34:3] near_distance,
                                      // [66:35] far_distance, [98:67] inverse_falloff
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [2:0]    csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BIS_START, ST_POW_LO, ST_POW_HI, ST_BIS_TEST, ST_CAS_START,
      ST_BLEND_DIV, ST_OVL_HI, ST_OVL_DIV, ST_INV_DIV, ST_EMIT, ST_ADV_LO, ST_ADV_HI
   } state_type;

   localparam int NumW = scs_pkg::DIV_NUM_W;

   state_type     state_ff;
   logic [2:0]    count_ff;
   logic [31:0]   cur_ff;
   logic [31:0]   d_ff;
   logic [2:0]    m_ff;
   logic [2:0]    i_ff;
   logic [2:0]    j_ff;
   logic [32:0]   lo_ff;
   logic [32:0]   hi_ff;
   logic [32:0]   p_ff;
   logic [32:0]   part_ff;
   logic [31:0]   r_ff;
   logic [31:0]   user_ff;
   logic [32:0]   opt_ff;
   logic          ge_ff;
   logic [32:0]   split_ff;
   logic [31:0]   near_ff;
   logic [31:0]   far_ff;
   logic [31:0]   inv_ff;
   logic [16:0]   ovl_qhi_ff;
   logic [2:0]    ovl_rem_ff;
   logic          div_start_ff;
   logic [NumW-1:0] div_num_ff;
   logic [31:0]   div_den_ff;
   logic          rsp_valid_ff;
   logic          rsp_last_ff;
   logic [2:0]    rsp_idx_ff;
   logic [31:0]   rsp_near_ff;
   logic [31:0]   rsp_far_ff;
   logic [31:0]   rsp_inv_ff;

   logic          div_done;
   logic [NumW-1:0] div_quo;

   logic [31:0]   d_w;
   logic [2:0]    n_w;
   logic [31:0]   mid_w;
   logic [32:0]   mul_a;
   logic [31:0]   mul_b;
   logic [15:0]   mul_b16;
   logic [48:0]   mul_prod;
   logic [49:0]   mul_full;
   logic [32:0]   mul_capped;
   logic          pow_fits;
   logic          ge_w;
   logic [32:0]   diff_w;
   logic [5:0]    w_w;
   logic [5:0]    den_w;
   logic [NumW-1:0] blend_num_w;
   logic [32:0]   split_blend_w;
   logic [18:0]   ovl_arg_w;
   logic [38:0]   ovl_prod_w;
   logic [16:0]   ovl_quo_w;
   logic [16:0]   ovl_rem_w;
   logic [32:0]   fifth_w;
   logic [33:0]   far_sum_w;
   logic [31:0]   far_sat_w;
   logic [34:0]   user5_w;
   logic [34:0]   user_half_w;
   logic [31:0]   user_next_w;
   logic          emit_go;
   logic          div_go;

   // clamped request and cascade count in use
   always_comb begin
      d_w = (req_tdata < scs_pkg::MIN_DISTANCE) ? scs_pkg::MIN_DISTANCE : req_tdata;
      n_w = count_ff;
      if (count_ff == 3'd0) begin
         n_w = 3'd1;
      end else if (int'(count_ff) > scs_pkg::MAX_CASCADES) begin
         n_w = 3'(scs_pkg::MAX_CASCADES);
      end
   end

   // shared multiplier: (a * b) >> 16 in two halves of b, capped
   always_comb begin
      mid_w = 32'((34'(lo_ff) + 34'(hi_ff)) >> 1);
      priority if (state_ff == ST_POW_LO || state_ff == ST_POW_HI) begin
         mul_a = p_ff;
         mul_b = mid_w;
      end else begin
         mul_a = opt_ff;
         mul_b = r_ff;
      end
      mul_b16    = (state_ff == ST_POW_HI || state_ff == ST_ADV_HI) ? mul_b[31:16]
                                                                    : mul_b[15:0];
      mul_prod   = 49'(mul_a) * 49'(mul_b16);
      mul_full   = 50'(mul_prod) + 50'(part_ff);
      mul_capped = (mul_full > 50'(scs_pkg::POW_CAP)) ? scs_pkg::POW_CAP : mul_full[32:0];
      pow_fits   = {p_ff, 1'b0} <= {2'b00, d_ff};
   end

   // blend, overlap and series update
   always_comb begin
      ge_w          = opt_ff >= {1'b0, user_ff};
      diff_w        = ge_w ? (opt_ff - {1'b0, user_ff}) : ({1'b0, user_ff} - opt_ff);
      w_w           = {3'b000, i_ff} * {3'b000, i_ff};
      den_w         = {3'b000, m_ff} * {3'b000, m_ff};
      blend_num_w   = NumW'(diff_w) * NumW'(w_w);
      split_blend_w = ge_ff ? ({1'b0, user_ff} + div_quo[32:0])
                            : ({1'b0, user_ff} - div_quo[32:0]);
      // split / 5 in two 16-bit digits, the upper digit first
      ovl_arg_w     = (state_ff == ST_OVL_HI) ? {2'b00, split_ff[32:16]}
                                              : {ovl_rem_ff, split_ff[15:0]};
      ovl_prod_w    = {20'd0, ovl_arg_w} * {19'd0, scs_pkg::RECIP5};
      ovl_quo_w     = ovl_prod_w[38:22];
      ovl_rem_w     = split_ff[32:16] - ((ovl_quo_w << 2) + ovl_quo_w);
      fifth_w       = {ovl_qhi_ff, 16'h0000} + {17'd0, ovl_quo_w[15:0]};
      far_sum_w     = 34'(split_ff) + 34'(fifth_w);
      far_sat_w     = (far_sum_w[33:32] != 2'b00) ? 32'hFFFF_FFFF : far_sum_w[31:0];
      user5_w       = (35'(user_ff) << 2) + 35'(user_ff);
      user_half_w   = user5_w >> 1;
      user_next_w   = (user_half_w > 35'(d_ff)) ? d_ff : user_half_w[31:0];
      emit_go       = !rsp_valid_ff || rsp_tready;
   end

   // divider start: one-cascade falloff, blend, last-cascade falloff
   always_comb begin
      div_go = (state_ff == ST_IDLE && req_tvalid && d_w != cur_ff && n_w == 3'd1) ||
               (state_ff == ST_CAS_START && i_ff != m_ff) ||
               (state_ff == ST_OVL_DIV && i_ff == m_ff);
   end

   // csr write
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd1;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_start_ff <= div_go;
         if (rsp_tready && !(state_ff == ST_EMIT && emit_go)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && d_w != cur_ff) begin
                  cur_ff   <= d_w;
                  d_ff     <= d_w;
                  m_ff     <= n_w - 3'd1;
                  i_ff     <= '0;
                  user_ff  <= 32'(scs_pkg::TWO_Q);
                  opt_ff   <= scs_pkg::TWO_Q;
                  near_ff  <= '0;
                  part_ff  <= '0;
                  lo_ff    <= '0;
                  hi_ff    <= scs_pkg::POW_CAP;
                  if (n_w == 3'd1) begin
                     far_ff     <= d_w;
                     div_num_ff <= (NumW'(5) << 32) + NumW'(d_w >> 1);
                     div_den_ff <= d_w;
                     state_ff   <= ST_INV_DIV;
                  end else begin
                     state_ff <= ST_BIS_START;
                  end
               end
            end
            ST_BIS_START: begin
               if (hi_ff - lo_ff > 33'd1) begin
                  p_ff     <= scs_pkg::ONE_Q;
                  j_ff     <= '0;
                  state_ff <= ST_POW_LO;
               end else begin
                  r_ff     <= lo_ff[31:0];
                  state_ff <= ST_CAS_START;
               end
            end
            ST_POW_LO: begin
               part_ff  <= mul_prod[48:16];
               state_ff <= ST_POW_HI;
            end
            ST_POW_HI: begin
               p_ff    <= mul_capped;
               part_ff <= '0;
               if (j_ff + 3'd1 == m_ff) begin
                  state_ff <= ST_BIS_TEST;
               end else begin
                  j_ff     <= j_ff + 3'd1;
                  state_ff <= ST_POW_LO;
               end
            end
            ST_BIS_TEST: begin
               if (pow_fits) begin
                  lo_ff <= {1'b0, mid_w};
               end else begin
                  hi_ff <= {1'b0, mid_w};
               end
               state_ff <= ST_BIS_START;
            end
            ST_CAS_START: begin
               if (i_ff == m_ff) begin
                  split_ff <= {1'b0, d_ff};
                  state_ff <= ST_OVL_HI;
               end else begin
                  ge_ff      <= ge_w;
                  div_num_ff <= blend_num_w;
                  div_den_ff <= 32'(den_w);
                  state_ff   <= ST_BLEND_DIV;
               end
            end
            ST_BLEND_DIV: begin
               if (div_done) begin
                  split_ff <= split_blend_w;
                  state_ff <= ST_OVL_HI;
               end
            end
            ST_OVL_HI: begin
               ovl_qhi_ff <= ovl_quo_w;
               ovl_rem_ff <= ovl_rem_w[2:0];
               state_ff   <= ST_OVL_DIV;
            end
            ST_OVL_DIV: begin
               far_ff <= far_sat_w;
               if (i_ff == m_ff) begin
                  div_num_ff <= (NumW'(5) << 32) + NumW'(far_sat_w >> 1);
                  div_den_ff <= far_sat_w;
                  state_ff   <= ST_INV_DIV;
               end else begin
                  inv_ff   <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_INV_DIV: begin
               if (div_done) begin
                  inv_ff   <= (div_quo[NumW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= i_ff;
                  rsp_near_ff  <= near_ff;
                  rsp_far_ff   <= far_ff;
                  rsp_inv_ff   <= inv_ff;
                  rsp_last_ff  <= i_ff == m_ff;
                  if (i_ff == m_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     near_ff  <= split_ff[32] ? 32'hFFFF_FFFF : split_ff[31:0];
                     user_ff  <= user_next_w;
                     part_ff  <= '0;
                     state_ff <= ST_ADV_LO;
                  end
               end
            end
            ST_ADV_LO: begin
               part_ff  <= mul_prod[48:16];
               state_ff <= ST_ADV_HI;
            end
            ST_ADV_HI: begin
               opt_ff   <= mul_capped;
               part_ff  <= '0;
               i_ff     <= i_ff + 3'd1;
               state_ff <= ST_CAS_START;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   scs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b00000, rsp_inv_ff, rsp_far_ff, rsp_near_ff, rsp_idx_ff};

   // only the final cascade carries a falloff, and it is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_inv_ff == 32'd0) == !rsp_last_ff))
      else $error("falloff does not match last flag");

   // the first cascade always starts at zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idx_ff == 3'd0) |-> (rsp_near_ff == 32'd0))
      else $error("first cascade near is not zero");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_BLEND_DIV || state_ff == ST_INV_DIV))
      else $error("divider result with no waiting step");

   // bisection bounds stay ordered
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BIS_TEST) |-> (lo_ff < hi_ff))
      else $error("bisection bounds crossed");

endmodule

// ===== dv/tb_shadow_cascade_split.sv =====
module tb_shadow_cascade_split;

   typedef struct packed {
      logic [2:0]  cascade_index;
      logic [31:0] near_distance;
      logic [31:0] far_distance;
      logic [31:0] inverse_falloff;
      logic        last_cascade;
   } split_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [31:0]  value;
      bit           typed;
      logic [31:0]  far_typed;
      logic [31:0]  inv_typed;
   } row_type;

   localparam int SETTLE_CYCLES = 800;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [31:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [103:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we;
   logic [2:0]    csr_wdata;

   // model state
   logic [2:0]  model_count;
   logic [31:0] model_distance;
   split_type   split_queue[$];
   int          fail_count;
   int          send_idle_pct;
   int          rsp_stall_pct;

   shadow_cascade_split dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #60000000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [63:0] sat_u32(logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic logic [63:0] power_q(logic [63:0] r, int k);
      logic [63:0] p;
      p = 64'(scs_pkg::ONE_Q);
      for (int j = 0; j < k; j++) begin
         p = (p * r) >> 16;
         if (p > 64'(scs_pkg::POW_CAP)) p = 64'(scs_pkg::POW_CAP);
      end
      return p;
   endfunction

   function automatic logic [63:0] falloff_inverse(logic [63:0] far_v);
      logic [63:0] num;
      num = 64'd5 << 32;
      if (far_v == 0) return 64'hFFFF_FFFF;
      return sat_u32((num + (far_v >> 1)) / far_v);
   endfunction

   // splits caused by one accepted distance, updates the stored distance
   function automatic void predict_splits(logic [31:0] req_d, ref split_type res[$]);
      logic [63:0] d, lo, hi, mid, user, opt, near_v, split_v, far_v, w, den;
      int n, m;
      split_type s;
      d = 64'(req_d);
      res.delete();
      if (d < 64'(scs_pkg::MIN_DISTANCE)) d = 64'(scs_pkg::MIN_DISTANCE);
      if (d[31:0] == model_distance) return;
      model_distance = d[31:0];
      n = int'(model_count);
      if (n < 1) n = 1;
      if (n > scs_pkg::MAX_CASCADES) n = scs_pkg::MAX_CASCADES;
      if (n == 1) begin
         s = '{3'd0, 32'd0, d[31:0], 32'(falloff_inverse(d)), 1'b1};
         res.push_back(s);
         return;
      end
      m = n - 1;
      // bisection for the geometric scale
      lo = 0;
      hi = 64'(scs_pkg::POW_CAP);
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (2 * power_q(mid, m) <= d) lo = mid;
         else hi = mid;
      end
      user = 64'(scs_pkg::TWO_Q);
      opt = 64'(scs_pkg::TWO_Q);
      near_v = 0;
      for (int i = 0; i < n; i++) begin
         if (i == m) begin
            split_v = d;
         end else begin
            w = 64'(i * i);
            den = 64'(m * m);
            if (opt >= user) split_v = user + ((opt - user) * w) / den;
            else split_v = user - ((user - opt) * w) / den;
         end
         far_v = sat_u32(split_v + split_v / 5);
         s.cascade_index = i[2:0];
         s.near_distance = near_v[31:0];
         s.far_distance = far_v[31:0];
         s.inverse_falloff = (i == m) ? 32'(falloff_inverse(far_v)) : 32'd0;
         s.last_cascade = (i == m);
         res.push_back(s);
         near_v = sat_u32(split_v);
         user = (user * 5) / 2;
         opt = (opt * lo) >> 16;
         if (opt > 64'(scs_pkg::POW_CAP)) opt = 64'(scs_pkg::POW_CAP);
         if (user > d) user = d;
      end
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      split_type exp_s;
      split_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[66:35],
                 rsp_tdata[98:67], rsp_tlast};
         if (split_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            fail_count++;
         end else begin
            exp_s = split_queue.pop_front();
            if (got !== exp_s || rsp_tdata[103:99] !== 5'd0) begin
               $display("%0t: mismatch expected idx %0d near %h far %h inv %h last %b",
                        $time, exp_s.cascade_index, exp_s.near_distance,
                        exp_s.far_distance, exp_s.inverse_falloff, exp_s.last_cascade);
               $display("%0t:          actual idx %0d near %h far %h inv %h last %b pad %h",
                        $time, got.cascade_index, got.near_distance, got.far_distance,
                        got.inverse_falloff, got.last_cascade, rsp_tdata[103:99]);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // one request transaction, with optional idle gap before it
   task automatic send_distance(logic [31:0] d, bit typed, logic [31:0] far_t,
                                logic [31:0] inv_t);
      split_type res[$];
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_splits(d, res);
      if (typed && res.size() != 0)
         split_queue.push_back('{3'd0, 32'd0, far_t, inv_t, 1'b1});
      else
         foreach (res[k]) split_queue.push_back(res[k]);
   endtask

   // wait for the block to drain before a register write
   task automatic drain_wait();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (split_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [2:0] v);
      drain_wait();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      model_count = v;
   endtask

   function automatic logic [31:0] random_distance(logic [31:0] prev);
      case ($urandom_range(9))
         0: return prev;
         1: return $urandom_range(0, 80);
         2, 3: return $urandom();
         4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(1, 400) << 16 | $urandom_range(0, 65535);
      endcase
   endfunction

   row_type rows[$];

   initial begin
      logic [31:0] last_d;
      req_tvalid = 0;
      req_tdata = 0;
      rsp_tready = 0;
      csr_we = 0;
      csr_wdata = 0;
      fail_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      model_count = 3'd1;
      model_distance = 32'd0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed table: zero clamps to the minimum, repeats give nothing
      rows = '{
         '{ROW_ITEM, 32'd0, 1'b1, 32'd66, 32'd325376310},
         '{ROW_ITEM, 32'd0, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd66, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd5},
         '{ROW_CFG, 32'd4, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd1000 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd0, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd2 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd3 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_CFG, 32'd0, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd5 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_CFG, 32'd7, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd100 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0},
         '{ROW_CFG, 32'd2, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd50 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd1, 1'b0, 32'd0, 32'd0},
         '{ROW_CFG, 32'd3, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'd7 << 16, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'hAAAA_AAAA, 1'b0, 32'd0, 32'd0},
         '{ROW_ITEM, 32'h5555_5555, 1'b0, 32'd0, 32'd0}
      };
      foreach (rows[k]) begin
         if (rows[k].kind == ROW_CFG) write_count(rows[k].value[2:0]);
         else send_distance(rows[k].value, rows[k].typed, rows[k].far_typed,
                            rows[k].inv_typed);
      end
      last_d = 32'h5555_5555;

      // random phases: no idling, sender idle, receiver stall, both, no idling again
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 46; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 46; end
            3: begin send_idle_pct = 24; rsp_stall_pct = 24; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         write_count((ph == 0) ? 3'd4 : (ph == 1) ? 3'd1 : 3'($urandom_range(0, 7)));
         for (int k = 0; k < 56; k++) begin
            if (k == 28 && ph == 3) drain_wait();
            if (k == 20) write_count(3'($urandom_range(0, 7)));
            last_d = random_distance(last_d);
            send_distance(last_d, 1'b0, 32'd0, 32'd0);
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (split_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
